// ----- rtl/core/wsrd_pkg.sv -----
// Shared types and constants for the work-stealing range dispatcher.
// Used by the interfaces, the front, the back, the remainder unit and the top level.
package wsrd_pkg;

  localparam int MEMBER_W = 6;
  localparam int INDEX_W  = 31;
  localparam int RESULT_W = 32;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_MEMBERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEAL_STRIDE   = 1'b1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam int DIV_STEPS = 8;
  localparam int DIV_CNT_W = 3;
  localparam int PROBE_W   = 8;

  typedef struct packed {
    logic                is_req;
    logic                in_range;
    logic [MEMBER_W-1:0] member;
    logic [INDEX_W-1:0]  range_first;
    logic [INDEX_W-1:0]  range_end;
    logic [MEMBER_W-1:0] victim_start;
  } wsrd_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  start;
    logic [INDEX_W-1:0]  stop;
    logic [MEMBER_W-1:0] victim;
  } wsrd_row_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } wsrd_bstat_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_OWN,
    S_PROBE,
    S_CHECK,
    S_MOD,
    S_SAVE,
    S_RESULT
  } wsrd_state_t;

endpackage

// ----- rtl/core/wsrd_if.sv -----
// Channel interfaces for the dispatcher: request input, result output and register writes.
// Depends on wsrd_pkg for field widths.
interface wsrd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [wsrd_pkg::MEMBER_W-1:0] member;
  logic [wsrd_pkg::INDEX_W-1:0]  range_first;
  logic [wsrd_pkg::INDEX_W-1:0]  range_end;
  logic [wsrd_pkg::MEMBER_W-1:0] victim_start;
  modport source(output valid, opcode, member, range_first, range_end, victim_start,
                 input ready);
  modport sink(input valid, opcode, member, range_first, range_end, victim_start,
               output ready);
endinterface

interface wsrd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [wsrd_pkg::RESULT_W-1:0] work_index;
  logic                                 got_work;
  logic                                 was_stolen;
  logic [wsrd_pkg::MEMBER_W-1:0]        source_member;
  modport source(output valid, work_index, got_work, was_stolen, source_member,
                 input ready);
  modport sink(input valid, work_index, got_work, was_stolen, source_member,
               output ready);
endinterface

interface wsrd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [wsrd_pkg::CFG_IDX_W-1:0] index;
  logic [wsrd_pkg::CFG_W-1:0]     data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/wsrd_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wsrd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/wsrd_remu.sv -----
// Bit-serial remainder unit for advancing the victim pointer modulo the pool size.
// Depends on wsrd_pkg for step counts.
module wsrd_remu (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [6:0] divisor,
  output logic       done,
  output logic [6:0] rem
);
  logic                           busy;
  logic [wsrd_pkg::DIV_CNT_W-1:0] cnt;
  logic [7:0]                     quo;
  logic [7:0]                     part;
  logic [6:0]                     div;
  logic [7:0]                     trial;

  assign trial = {part[6:0], quo[7]};
  assign rem = part[6:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        div  <= divisor;
        part <= '0;
      end else if (busy) begin
        quo <= {quo[6:0], 1'b0};
        if (trial >= {1'b0, div}) begin
          part <= trial - {1'b0, div};
        end else begin
          part <= trial;
        end
        cnt <= cnt + 1'b1;
        if (cnt == wsrd_pkg::DIV_CNT_W'(wsrd_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- rtl/core/wsrd_front.sv -----
// Front end: accepts items, classifies them and holds them in a two-entry queue.
// Depends on wsrd_pkg and wsrd_in_if.
module wsrd_front #(
  parameter int MAX_MEMBERS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  wsrd_in_if.sink              req,
  input  logic                 clearing,
  output wsrd_pkg::wsrd_item_t item,
  output logic                 item_valid,
  input  logic                 item_ready
);
  wsrd_pkg::wsrd_item_t              entries [wsrd_pkg::QUEUE_DEPTH];
  logic [wsrd_pkg::QPTR_W-1:0]       wr_ptr;
  logic [wsrd_pkg::QPTR_W-1:0]       rd_ptr;
  logic [wsrd_pkg::QCNT_W-1:0]       count;
  wsrd_pkg::wsrd_item_t              incoming;
  logic                              push;
  logic                              pop;

  // Loads to members outside the tables have no effect and are dropped here.
  always_comb begin
    incoming.is_req       = (req.opcode == wsrd_pkg::OP_REQUEST);
    incoming.in_range     = (int'(req.member) < MAX_MEMBERS);
    incoming.member       = req.member;
    incoming.range_first  = req.range_first;
    incoming.range_end    = req.range_end;
    incoming.victim_start = req.victim_start;
  end

  assign req.ready  = (count != wsrd_pkg::QCNT_W'(wsrd_pkg::QUEUE_DEPTH)) && !clearing;
  assign push       = req.valid && req.ready && (incoming.is_req || incoming.in_range);
  assign item_valid = (count != '0);
  assign pop        = item_valid && item_ready;
  assign item       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= incoming;
    end
  end
endmodule

// ----- rtl/core/wsrd_back.sv -----
// Back end: member table, own-range grants, the victim walk and the result register.
// Depends on wsrd_pkg, wsrd_out_if, wsrd_ram and wsrd_remu.
module wsrd_back #(
  parameter int MAX_MEMBERS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  wsrd_pkg::wsrd_item_t  item,
  input  logic                  item_valid,
  output logic                  item_ready,
  input  logic [6:0]            eff_pool,
  input  logic [6:0]            steal_stride,
  wsrd_out_if.source            rsp,
  output wsrd_pkg::wsrd_bstat_t stat
);
  localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int XW = AW + 7;
  localparam int RW = $bits(wsrd_pkg::wsrd_row_t);

  wsrd_pkg::wsrd_state_t state, state_next;

  logic [AW-1:0]                     clr_cnt, clr_cnt_next;
  logic [wsrd_pkg::MEMBER_W-1:0]     m, m_next;
  logic [wsrd_pkg::INDEX_W-1:0]      os, os_next;
  logic [wsrd_pkg::INDEX_W-1:0]      oe, oe_next;
  logic [6:0]                        v, v_next;
  logic [wsrd_pkg::PROBE_W-1:0]      probes, probes_next;
  logic [wsrd_pkg::RESULT_W-1:0]     res_idx, res_idx_next;
  logic                              res_got, res_got_next;
  logic                              res_stolen, res_stolen_next;
  logic [wsrd_pkg::MEMBER_W-1:0]     res_src, res_src_next;
  logic                              out_valid;
  logic                              out_load;

  logic                              we;
  logic [AW-1:0]                     waddr, raddr;
  wsrd_pkg::wsrd_row_t               row_w, row_r;
  logic [RW-1:0]                     rdata;

  logic [XW-1:0]                     item_ext, m_ext, v_ext, clr_ext;
  logic [AW-1:0]                     item_addr, m_addr, v_addr;

  logic                              mod_start;
  logic                              mod_done;
  logic [6:0]                        mod_rem;

  assign item_ext  = XW'(item.member);
  assign m_ext     = XW'(m);
  assign v_ext     = XW'(v);
  assign clr_ext   = XW'(clr_cnt);
  assign item_addr = item_ext[AW-1:0];
  assign m_addr    = m_ext[AW-1:0];
  assign v_addr    = v_ext[AW-1:0];
  assign row_r     = wsrd_pkg::wsrd_row_t'(rdata);

  wsrd_ram #(
    .WIDTH(RW),
    .DEPTH(MAX_MEMBERS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(RW'(row_w)),
    .raddr(raddr),
    .rdata(rdata)
  );

  wsrd_remu u_remu (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(8'(v) + 8'(steal_stride)),
    .divisor (eff_pool),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    m_next          = m;
    os_next         = os;
    oe_next         = oe;
    v_next          = v;
    probes_next     = probes;
    res_idx_next    = res_idx;
    res_got_next    = res_got;
    res_stolen_next = res_stolen;
    res_src_next    = res_src;
    item_ready      = 1'b0;
    we              = 1'b0;
    waddr           = '0;
    raddr           = '0;
    row_w           = '0;
    mod_start       = 1'b0;
    out_load        = 1'b0;
    case (state)
      wsrd_pkg::S_CLEAR: begin
        we           = 1'b1;
        waddr        = clr_cnt;
        row_w.victim = clr_ext[wsrd_pkg::MEMBER_W-1:0];
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == AW'(MAX_MEMBERS - 1)) begin
          state_next = wsrd_pkg::S_IDLE;
        end
      end
      wsrd_pkg::S_IDLE: begin
        if (item_valid) begin
          item_ready      = 1'b1;
          m_next          = item.member;
          res_idx_next    = '1;
          res_got_next    = 1'b0;
          res_stolen_next = 1'b0;
          res_src_next    = item.member;
          if (!item.is_req) begin
            we           = 1'b1;
            waddr        = item_addr;
            row_w.start  = item.range_first;
            row_w.stop   = item.range_end;
            row_w.victim = item.victim_start;
          end else if (!item.in_range) begin
            state_next = wsrd_pkg::S_RESULT;
          end else begin
            raddr      = item_addr;
            state_next = wsrd_pkg::S_OWN;
          end
        end
      end
      wsrd_pkg::S_OWN: begin
        os_next = row_r.start;
        oe_next = row_r.stop;
        if (row_r.start < row_r.stop) begin
          we           = 1'b1;
          waddr        = m_addr;
          row_w.start  = row_r.start + 1'b1;
          row_w.stop   = row_r.stop;
          row_w.victim = row_r.victim;
          res_idx_next = {1'b0, row_r.start};
          res_got_next = 1'b1;
          state_next   = wsrd_pkg::S_RESULT;
        end else if (row_r.victim != m) begin
          v_next      = {1'b0, row_r.victim};
          probes_next = '0;
          state_next  = wsrd_pkg::S_PROBE;
        end else begin
          state_next = wsrd_pkg::S_RESULT;
        end
      end
      wsrd_pkg::S_PROBE: begin
        probes_next = probes + 1'b1;
        if (int'(v) < MAX_MEMBERS) begin
          raddr      = v_addr;
          state_next = wsrd_pkg::S_CHECK;
        end else begin
          mod_start  = 1'b1;
          state_next = wsrd_pkg::S_MOD;
        end
      end
      wsrd_pkg::S_CHECK: begin
        if (row_r.start < row_r.stop) begin
          we              = 1'b1;
          waddr           = v_addr;
          row_w.start     = row_r.start;
          row_w.stop      = row_r.stop - 1'b1;
          row_w.victim    = row_r.victim;
          res_idx_next    = {1'b0, row_r.stop - 1'b1};
          res_got_next    = 1'b1;
          res_stolen_next = 1'b1;
          res_src_next    = v[wsrd_pkg::MEMBER_W-1:0];
          state_next      = wsrd_pkg::S_SAVE;
        end else begin
          mod_start  = 1'b1;
          state_next = wsrd_pkg::S_MOD;
        end
      end
      wsrd_pkg::S_MOD: begin
        if (mod_done) begin
          v_next = mod_rem;
          if (mod_rem == {1'b0, m}) begin
            state_next = wsrd_pkg::S_SAVE;
          end else if (probes <= {1'b0, eff_pool}) begin
            state_next = wsrd_pkg::S_PROBE;
          end else begin
            state_next = wsrd_pkg::S_SAVE;
          end
        end
      end
      wsrd_pkg::S_SAVE: begin
        we           = 1'b1;
        waddr        = m_addr;
        row_w.start  = os;
        row_w.stop   = oe;
        row_w.victim = v[wsrd_pkg::MEMBER_W-1:0];
        state_next   = wsrd_pkg::S_RESULT;
      end
      wsrd_pkg::S_RESULT: begin
        if (!out_valid || rsp.ready) begin
          out_load   = 1'b1;
          state_next = wsrd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = wsrd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wsrd_pkg::S_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      clr_cnt <= clr_cnt_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    m          <= m_next;
    os         <= os_next;
    oe         <= oe_next;
    v          <= v_next;
    probes     <= probes_next;
    res_idx    <= res_idx_next;
    res_got    <= res_got_next;
    res_stolen <= res_stolen_next;
    res_src    <= res_src_next;
    if (out_load) begin
      rsp.work_index    <= res_idx;
      rsp.got_work      <= res_got;
      rsp.was_stolen    <= res_stolen;
      rsp.source_member <= res_src;
    end
  end

  assign rsp.valid     = out_valid;
  assign stat.clearing = (state == wsrd_pkg::S_CLEAR);
  assign stat.busy     = (state != wsrd_pkg::S_IDLE) && (state != wsrd_pkg::S_CLEAR);
endmodule

// ----- rtl/core/work_stealing_range_dispatcher_unit.sv -----
// Work-stealing range dispatcher, top level. A load transfer sets one member's half-open
// range and first victim; a request transfer returns the front index of the member's own
// range, or else the back index of the first non-empty victim range, or -1. After reset
// the block clears its member table and takes no requests until that is done; register
// writes are taken at any time. A steal probes victims in turn and advances the victim
// pointer with the bit-serial remainder unit, so the walk over the pool, bounded by the
// pool size plus one probes, sets the worst case. A two-entry queue lets the front take
// new transfers while the back works. Depends on wsrd_pkg, wsrd_if, wsrd_front and
// wsrd_back.
module work_stealing_range_dispatcher_unit #(
  parameter int MAX_MEMBERS = 64
) (
  input logic      clk,
  input logic      rst,
  wsrd_in_if.sink  req,
  wsrd_out_if.source rsp,
  wsrd_cfg_if.sink cfg
);
  logic [wsrd_pkg::CFG_W-1:0] active_members;
  logic [wsrd_pkg::CFG_W-1:0] steal_stride;
  logic [wsrd_pkg::CFG_W-1:0] eff_pool;
  wsrd_pkg::wsrd_item_t       item;
  logic                       item_valid;
  logic                       item_ready;
  wsrd_pkg::wsrd_bstat_t      stat;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_members <= wsrd_pkg::CFG_W'(1);
      steal_stride   <= wsrd_pkg::CFG_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        wsrd_pkg::CFG_ACTIVE_MEMBERS: active_members <= cfg.data;
        wsrd_pkg::CFG_STEAL_STRIDE:   steal_stride <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // A pool size of zero acts as one, and one above the table depth acts as the depth.
  always_comb begin
    if (active_members == '0) begin
      eff_pool = wsrd_pkg::CFG_W'(1);
    end else if (int'(active_members) > MAX_MEMBERS) begin
      eff_pool = wsrd_pkg::CFG_W'(MAX_MEMBERS);
    end else begin
      eff_pool = active_members;
    end
  end

  wsrd_front #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .clearing  (stat.clearing),
    .item      (item),
    .item_valid(item_valid),
    .item_ready(item_ready)
  );

  wsrd_back #(
    .MAX_MEMBERS(MAX_MEMBERS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .eff_pool    (eff_pool),
    .steal_stride(steal_stride),
    .rsp         (rsp),
    .stat        (stat)
  );

  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    stat.clearing |-> !req.ready)
    else $error("request channel ready during table clearing");

  a_no_work_is_minus_one: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.got_work) |-> (rsp.work_index == -32'sd1 && !rsp.was_stolen))
    else $error("empty result without -1 index or with stolen flag");

  a_stolen_implies_grant: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.was_stolen) |-> (rsp.got_work && rsp.work_index != -32'sd1))
    else $error("stolen result without a granted index");

  a_idle_back_after_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(stat.clearing) |-> !stat.busy)
    else $error("back end busy as table clearing ends");
endmodule
